### design/lu_pkg.sv
// Shared types and constants for the LU linear system solver.
`default_nettype none
package lu_pkg;
  localparam int DefMaxSize = 16;
  localparam int DefValueWidth = 32;
  localparam int FracBits = 16;
  localparam int SizeWidth = 5;
  localparam int IndexWidth = 4;
  localparam int CountWidth = 7;
  localparam logic [SizeWidth-1:0] SizeReset = 5'd4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FAC_INIT,
    ST_FAC_MAC,
    ST_FAC_END,
    ST_FWD_INIT,
    ST_FWD_MAC,
    ST_FWD_END,
    ST_BWD_INIT,
    ST_BWD_MAC,
    ST_BWD_END,
    ST_EMIT
  } lu_state_t;

  // Datapath operation selected for the current cycle.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_MAC,
    OP_FINISH,
    OP_EMIT
  } lu_op_t;

  // Phase of the run that the finishing step belongs to.
  typedef enum logic [1:0] {
    PH_FAC,
    PH_FWD,
    PH_BWD
  } lu_phase_t;

  typedef struct packed {
    lu_op_t                op;
    lu_phase_t             phase;
    logic [CountWidth-1:0] i;
    logic [CountWidth-1:0] k;
    logic [CountWidth-1:0] j;
    logic                  clear_err;
  } lu_cmd_t;

  typedef struct packed {
    logic finish_done;
  } lu_status_t;
endpackage
`default_nettype wire

### design/lu_divider.sv
// Restoring divider computing (num * 2^16) / den truncated, with saturation and an overflow flag.
`default_nettype none
module lu_divider import lu_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] num,
  input  wire logic signed [VALUE_WIDTH-1:0] den,
  output logic                               done,
  output logic signed [VALUE_WIDTH-1:0]      quot,
  output logic                               ovf
);
  localparam int QW = VALUE_WIDTH + FracBits;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dividend;
  logic [QW-1:0] q;
  logic [VALUE_WIDTH:0] rem;
  logic [VALUE_WIDTH-1:0] dmag;
  logic neg;
  logic zero_den;
  logic [CW-1:0] count;
  logic busy;
  logic [VALUE_WIDTH+1:0] trial;
  logic [VALUE_WIDTH:0] shifted;

  assign shifted = {rem[VALUE_WIDTH-1:0], dividend[QW-1]};
  assign trial = {1'b0, shifted} - {2'b00, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (count == CW'(1));
      if (start) begin
        busy <= 1'b1;
        count <= CW'(QW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {(num[VALUE_WIDTH-1] ? VALUE_WIDTH'(-num) : VALUE_WIDTH'(num)),
                   {FracBits{1'b0}}};
      dmag <= den[VALUE_WIDTH-1] ? VALUE_WIDTH'(-den) : VALUE_WIDTH'(den);
      neg <= num[VALUE_WIDTH-1] ^ den[VALUE_WIDTH-1];
      zero_den <= (den == '0);
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      dividend <= {dividend[QW-2:0], 1'b0};
      if (!trial[VALUE_WIDTH+1]) begin
        rem <= trial[VALUE_WIDTH:0];
        q <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q <= {q[QW-2:0], 1'b0};
      end
    end
  end

  logic [QW:0] lim;
  always_comb begin
    lim = neg ? (QW+1)'(1) << (VALUE_WIDTH-1) : ((QW+1)'(1) << (VALUE_WIDTH-1)) - 1'b1;
    ovf = 1'b0;
    if (zero_den) begin
      quot = '0;
      ovf = 1'b1;
    end else if ({1'b0, q} > lim) begin
      ovf = 1'b1;
      quot = neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else begin
      quot = neg ? VALUE_WIDTH'(-q) : VALUE_WIDTH'(q);
    end
  end
endmodule
`default_nettype wire

### design/lu_datapath.sv
// Storage, multiply-accumulate and divide datapath of the LU solver.
`default_nettype none
module lu_datapath import lu_pkg::*; #(
  parameter int MAX_SIZE    = DefMaxSize,
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load_we,
  input  wire logic [$clog2(MAX_SIZE*(MAX_SIZE+1))-1:0] load_addr,
  input  wire logic signed [VALUE_WIDTH-1:0] load_data,
  input  wire logic [$clog2(MAX_SIZE*(MAX_SIZE+1)+1)-1:0] load_count,
  input  wire logic [$clog2(MAX_SIZE+1)-1:0] size,
  input  wire lu_cmd_t                       cmd,
  output lu_status_t                         status,
  output logic signed [VALUE_WIDTH-1:0]      result,
  output logic                               error
);
  localparam int AD = MAX_SIZE * (MAX_SIZE + 1);
  localparam int AW = $clog2(AD);
  localparam int LW = $clog2(AD + 1);
  localparam int FD = MAX_SIZE * MAX_SIZE;
  localparam int FW = $clog2(FD);
  localparam int IW = $clog2(MAX_SIZE);
  localparam int NW = $clog2(MAX_SIZE + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * VW;
  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};

  logic signed [VW-1:0] aug_mem [AD];
  logic signed [VW-1:0] fac_mem [FD];
  logic signed [VW-1:0] vec_mem [MAX_SIZE];

  logic [IW-1:0] ci, ck, cj;
  assign ci = cmd.i[IW-1:0];
  assign ck = cmd.k[IW-1:0];
  assign cj = cmd.j[IW-1:0];

  // Read addresses per operation.
  logic [FW-1:0] fa_addr, fb_addr;
  logic [IW-1:0] v_addr;
  always_comb begin
    fa_addr = FW'(ci) * FW'(MAX_SIZE) + FW'(cj);
    fb_addr = FW'(cj) * FW'(MAX_SIZE) + FW'(ck);
    v_addr = cj;
    if (cmd.op == OP_FINISH) begin
      fb_addr = FW'(ci) * FW'(MAX_SIZE) + FW'(ci);
      v_addr = ck;
    end
  end

  logic [AW+1:0] flat;
  logic in_range;
  always_comb begin
    flat = (AW+2)'(ci) * (AW+2)'({1'b0, size} + 1'b1) + (AW+2)'(ck);
    if (cmd.phase != PH_FAC) flat = (AW+2)'(ck) * (AW+2)'({1'b0, size} + 1'b1) + (AW+2)'(size);
    in_range = (flat < (AW+2)'(load_count));
  end

  logic signed [VW-1:0] fa_q, fb_q, v_q, aug_q;
  logic aug_ok;
  always_ff @(posedge clk) begin
    if (load_we) aug_mem[load_addr] <= load_data;
    fa_q <= fac_mem[fa_addr];
    fb_q <= fac_mem[fb_addr];
    v_q <= vec_mem[v_addr];
    aug_q <= aug_mem[AW'(flat)];
    aug_ok <= in_range;
  end

  // Pipeline of control after the registered reads.
  lu_cmd_t cmd1, cmd2;
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd1 <= '0;
      cmd2 <= '0;
    end else begin
      cmd1 <= cmd;
      cmd2 <= cmd1;
    end
  end

  // Multiplier stage.
  logic signed [VW-1:0] mb;
  assign mb = (cmd1.phase == PH_FAC) ? fb_q : v_q;
  logic signed [PW-1:0] prod;
  always_ff @(posedge clk) prod <= fa_q * mb;

  logic signed [PW:0] rounded;
  logic signed [PW:0] shr;
  logic signed [VW-1:0] mulv;
  logic mul_ovf;
  always_comb begin
    rounded = {prod[PW-1], prod} + (PW+1)'(1 << (FracBits-1));
    shr = rounded >>> FracBits;
    mul_ovf = 1'b0;
    mulv = shr[VW-1:0];
    if (shr > (PW+1)'(VMax)) begin
      mulv = VMax;
      mul_ovf = 1'b1;
    end else if (shr < (PW+1)'(VMin)) begin
      mulv = VMin;
      mul_ovf = 1'b1;
    end
  end

  function automatic logic signed [VW:0] sext(input logic signed [VW-1:0] a);
    sext = {a[VW-1], a};
  endfunction

  logic signed [VW-1:0] acc;
  logic signed [VW:0] sum;
  assign sum = sext(acc) + sext(mulv);

  // Finishing step: subtract accumulator from the base value.
  logic signed [VW-1:0] base;
  logic signed [VW:0] diff;
  logic signed [VW-1:0] diffs;
  logic diff_ovf;
  always_comb begin
    base = aug_ok ? aug_q : '0;
    if (cmd1.phase == PH_BWD) base = v_q;
    diff = sext(base) - sext(acc);
    diffs = diff[VW-1:0];
    diff_ovf = 1'b0;
    if (diff > sext(VMax)) begin
      diffs = VMax;
      diff_ovf = 1'b1;
    end else if (diff < sext(VMin)) begin
      diffs = VMin;
      diff_ovf = 1'b1;
    end
  end

  logic div_start, div_done, div_ovf;
  logic signed [VW-1:0] div_q;
  logic need_div;
  lu_cmd_t fcmd;
  logic fin_wait;

  assign need_div = (cmd1.phase == PH_FWD) ||
                    (cmd1.phase == PH_FAC && cmd1.i < cmd1.k);
  assign div_start = (cmd1.op == OP_FINISH) && need_div;

  lu_divider #(.VALUE_WIDTH(VW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(diffs), .den(fb_q),
    .done(div_done), .quot(div_q), .ovf(div_ovf)
  );

  logic wr_en;
  logic signed [VW-1:0] wr_val;
  always_comb begin
    wr_en = 1'b0;
    wr_val = diffs;
    if (cmd1.op == OP_FINISH && !need_div) wr_en = 1'b1;
    if (fin_wait && div_done) begin
      wr_en = 1'b1;
      wr_val = div_q;
    end
  end

  logic mac_ovf;
  logic error_next, fin_wait_next, finish_next;
  assign mac_ovf = mul_ovf || (sum > sext(VMax)) || (sum < sext(VMin));

  always_comb begin
    error_next = error;
    fin_wait_next = fin_wait;
    finish_next = 1'b0;
    if (cmd.clear_err) error_next = 1'b0;
    if (cmd2.op == OP_MAC && mac_ovf) error_next = 1'b1;
    if (cmd1.op == OP_FINISH) begin
      if (diff_ovf) error_next = 1'b1;
      if (need_div) fin_wait_next = 1'b1;
      else finish_next = 1'b1;
    end
    if (fin_wait && div_done) begin
      fin_wait_next = 1'b0;
      finish_next = 1'b1;
      if (div_ovf) error_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error <= 1'b0;
      fin_wait <= 1'b0;
      status <= '0;
    end else begin
      error <= error_next;
      fin_wait <= fin_wait_next;
      status.finish_done <= finish_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) acc <= '0;
    else if (cmd2.op == OP_MAC) begin
      if (sum > sext(VMax)) acc <= VMax;
      else if (sum < sext(VMin)) acc <= VMin;
      else acc <= sum[VW-1:0];
    end
    if (cmd1.op == OP_FINISH) fcmd <= cmd1;
    if (wr_en) begin
      if ((fin_wait ? fcmd.phase : cmd1.phase) == PH_FAC)
        fac_mem[FW'((fin_wait ? fcmd.i : cmd1.i)) * FW'(MAX_SIZE) +
                FW'((fin_wait ? fcmd.k : cmd1.k))] <= wr_val;
      else
        vec_mem[IW'(fin_wait ? fcmd.k : cmd1.k)] <= wr_val;
    end
    if (cmd1.op == OP_EMIT) result <= v_q;
  end

  logic unused;
  assign unused = ^{cmd2.phase, cmd2.i, cmd2.k, cmd2.j, cmd2.clear_err, NW'(0), LW'(0)};

`ifndef SYNTHESIS
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> fin_wait) else $error("divider finished with no pending step");
  a_no_double_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !fin_wait) else $error("divider started while busy");
  a_finish_pulse: assert property (@(posedge clk) disable iff (rst)
    status.finish_done |=> !status.finish_done) else $error("finish held");
`endif
endmodule
`default_nettype wire

### design/lu_controller.sv
// Sequencing state machine of the LU solver.
`default_nettype none
module lu_controller import lu_pkg::*; #(
  parameter int MAX_SIZE = DefMaxSize
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          last_element,
  input  wire logic [$clog2(MAX_SIZE+1)-1:0] size,
  input  wire lu_status_t                    status,
  output lu_cmd_t                            cmd,
  output logic                               busy,
  output logic                               emit,
  output logic [IndexWidth-1:0]              emit_index,
  output logic                               emit_last
);
  localparam int CW = CountWidth;

  lu_state_t state, state_next;
  logic [CW-1:0] i, k, j, lim;
  logic [2:0] emit_pipe;
  logic [CW-1:0] ep0, ep1, ep2;
  logic [CW-1:0] n;
  logic [CW-1:0] last_k;
  assign n = CW'(size);
  assign last_k = n - CW'(1);

  always_comb begin
    lim = '0;
    unique case (state)
      ST_FAC_INIT, ST_FAC_MAC: lim = (i < k) ? i : k;
      ST_FWD_INIT, ST_FWD_MAC: lim = k;
      ST_BWD_INIT, ST_BWD_MAC: lim = n;
      default: lim = '0;
    endcase
  end

  logic mac_done;
  assign mac_done = (j + CW'(1) >= lim);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (start && last_element) state_next = ST_FAC_INIT;
      ST_FAC_INIT: state_next = (lim == '0) ? ST_FAC_END : ST_FAC_MAC;
      ST_FAC_MAC: if (mac_done) state_next = ST_FAC_END;
      ST_FAC_END: if (status.finish_done)
        state_next = (i == last_k && k == last_k) ? ST_FWD_INIT : ST_FAC_INIT;
      ST_FWD_INIT: state_next = (k == '0) ? ST_FWD_END : ST_FWD_MAC;
      ST_FWD_MAC: if (mac_done) state_next = ST_FWD_END;
      ST_FWD_END: if (status.finish_done)
        state_next = (k == last_k) ? ST_BWD_INIT : ST_FWD_INIT;
      ST_BWD_INIT: state_next = (k + CW'(1) >= n) ? ST_BWD_END : ST_BWD_MAC;
      ST_BWD_MAC: if (mac_done) state_next = ST_BWD_END;
      ST_BWD_END: if (status.finish_done)
        state_next = (k == '0) ? ST_EMIT : ST_BWD_INIT;
      ST_EMIT: if (k == last_k) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  lu_cmd_t cmd_base;
  always_comb begin
    cmd_base = '0;
    cmd_base.op = OP_IDLE;
    cmd_base.phase = PH_FAC;
    cmd_base.i = i;
    cmd_base.k = k;
    cmd_base.j = j;
    unique case (state)
      ST_LOAD: cmd_base.clear_err = start && last_element;
      ST_FAC_INIT, ST_FWD_INIT, ST_BWD_INIT: cmd_base.op = OP_CLEAR;
      ST_FAC_MAC, ST_FWD_MAC, ST_BWD_MAC: cmd_base.op = OP_MAC;
      ST_EMIT: cmd_base.op = OP_EMIT;
      default: cmd_base.op = OP_IDLE;
    endcase
    unique case (state)
      ST_FWD_INIT, ST_FWD_MAC, ST_FWD_END: cmd_base.phase = PH_FWD;
      ST_BWD_INIT, ST_BWD_MAC, ST_BWD_END: cmd_base.phase = PH_BWD;
      ST_EMIT: cmd_base.phase = PH_BWD;
      default: cmd_base.phase = PH_FAC;
    endcase
    if (state == ST_BWD_MAC || state == ST_FWD_MAC || state == ST_FWD_END)
      cmd_base.i = k;
    if (state == ST_EMIT) cmd_base.j = k;
  end

  // A finish command is issued only once in each end state.
  logic end_issued, end_issued_next;
  lu_cmd_t fin_cmd;
  always_comb begin
    fin_cmd = cmd_base;
    if ((state == ST_FAC_END || state == ST_FWD_END || state == ST_BWD_END) && !end_issued)
      fin_cmd.op = OP_FINISH;
  end

  // Pipeline drain: the last MAC must land before finish reads the accumulator.
  logic [1:0] drain, drain_next;

  always_comb begin
    drain_next = drain;
    end_issued_next = end_issued;
    if (state == ST_FAC_END || state == ST_FWD_END || state == ST_BWD_END) begin
      if (drain != 2'd3) drain_next = drain + 2'd1;
      else end_issued_next = 1'b1;
    end
    if (state_next != state || status.finish_done) begin
      end_issued_next = 1'b0;
      drain_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      end_issued <= 1'b0;
      drain <= 2'd0;
      emit_pipe <= '0;
    end else begin
      end_issued <= end_issued_next;
      drain <= drain_next;
      state <= state_next;
      emit_pipe <= {emit_pipe[1:0], state == ST_EMIT};
    end
  end

  assign busy = (state != ST_LOAD) || (emit_pipe != '0);

  // Command output: finish is held back until the pipeline has drained.
  always_comb begin
    if (fin_cmd.op == OP_FINISH && drain != 2'd3) cmd = cmd_base;
    else cmd = fin_cmd;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        i <= '0; k <= '0; j <= '0;
      end
      ST_FAC_INIT, ST_FWD_INIT: j <= '0;
      ST_BWD_INIT: j <= k + CW'(1);
      ST_FAC_MAC, ST_FWD_MAC, ST_BWD_MAC: j <= j + CW'(1);
      ST_FAC_END: if (status.finish_done) begin
        if (k == last_k) begin
          k <= '0;
          i <= (i == last_k) ? '0 : i + CW'(1);
        end else begin
          k <= k + CW'(1);
        end
      end
      ST_FWD_END: if (status.finish_done) k <= (k == last_k) ? last_k : k + CW'(1);
      ST_BWD_END: if (status.finish_done) k <= (k == '0) ? '0 : k - CW'(1);
      ST_EMIT: k <= k + CW'(1);
      default: j <= j;
    endcase
    ep0 <= k;
    ep1 <= ep0;
    ep2 <= ep1;
  end

  assign emit = emit_pipe[1];
  assign emit_index = ep1[IndexWidth-1:0];
  assign emit_last = emit_pipe[1] && (ep1 == last_k);

  logic unused;
  assign unused = ^{ep2, emit_pipe[2]};

`ifndef SYNTHESIS
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_element) |=> busy) else $error("solve did not start");
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    emit |-> (ep1 < n)) else $error("emit index out of range");
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    emit |-> busy) else $error("emit while idle");
`endif
endmodule
`default_nettype wire

### design/lu_linear_system_solver_core.sv
// Top level of the Crout LU linear system solver.
`default_nettype none
// Elements load at one per cycle while busy is low; the marked element starts
// a solve during which busy is high and size writes are held off. The solve
// runs on one multiply-accumulate unit over about n^3/3 + n^2 terms, and on
// one shared serial divider. Each of the n^2+2n finishing steps follows a
// setup state and its terms, then waits for the pipeline to drain before its
// write-back, and n(n+1)/2 of them also wait for a division. The n results
// then appear on consecutive cycles with result_valid high; the receiver
// cannot stall them and must take each one.
module lu_linear_system_solver_core import lu_pkg::*; #(
  parameter int MAX_SIZE    = DefMaxSize,
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] element_value,
  input  wire logic                          last_element,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [SizeWidth-1:0]          cfg_data,
  output logic                               result_valid,
  output logic signed [VALUE_WIDTH-1:0]      solution_value,
  output logic [IndexWidth-1:0]              solution_index,
  output logic                               singular_error,
  output logic                               last_result
);
  localparam int AD = MAX_SIZE * (MAX_SIZE + 1);
  localparam int AW = $clog2(AD);
  localparam int LW = $clog2(AD + 1);
  localparam int NW = $clog2(MAX_SIZE + 1);

  logic [SizeWidth-1:0] size_reg;
  logic [NW-1:0] n;
  logic [LW-1:0] load_position;
  logic [2*NW+1:0] total;
  logic accept;
  lu_cmd_t cmd;
  lu_status_t status;
  logic emit, emit_last;
  logic [IndexWidth-1:0] emit_index;
  logic signed [VALUE_WIDTH-1:0] result;
  logic error;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) size_reg <= SizeReset;
    else if (cfg_valid && cfg_ready) size_reg <= cfg_data;
  end

  always_comb begin
    if (size_reg < 5'd2) n = NW'(2);
    else if (32'(size_reg) > MAX_SIZE) n = NW'(MAX_SIZE);
    else n = NW'(size_reg);
  end

  assign total = (2*NW+2)'(n) * (2*NW+2)'(n + 1'b1);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) load_position <= '0;
    else if (accept) begin
      if (last_element) load_position <= '0;
      else if ((2*NW+2)'(load_position) < total) load_position <= load_position + 1'b1;
    end
  end

  logic load_we;
  logic [LW-1:0] count_eff;
  assign load_we = accept && ((2*NW+2)'(load_position) < total);
  assign count_eff = load_position;

  // Count including the marked element, held for the solve.
  logic [LW-1:0] solve_count;
  always_ff @(posedge clk) begin
    if (accept && last_element) solve_count <= load_we ? count_eff + 1'b1 : count_eff;
  end

  lu_controller #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk(clk), .rst(rst), .start(accept), .last_element(last_element),
    .size(n), .status(status), .cmd(cmd), .busy(busy),
    .emit(emit), .emit_index(emit_index), .emit_last(emit_last)
  );

  lu_datapath #(.MAX_SIZE(MAX_SIZE), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .load_we(load_we), .load_addr(AW'(load_position)),
    .load_data(element_value), .load_count(solve_count), .size(n),
    .cmd(cmd), .status(status), .result(result), .error(error)
  );

  assign result_valid = emit;
  assign solution_value = result;
  assign solution_index = emit_index;
  assign singular_error = error;
  assign last_result = emit_last;
endmodule
`default_nettype wire
